/* design/htsd_pkg.sv */
// Shared types and constants for the Huffman tree stream decoder.
package htsd_pkg;

    localparam int NODE_W      = 9;
    localparam int STACK_W     = 10;
    localparam int SYM_W       = 8;
    localparam int COUNT_W     = 32;
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = 8;
    localparam int DEPTH_W     = 9;
    localparam int BIT_IDX_W   = 3;
    localparam int HDR_IDX_W   = 2;
    localparam int LEAF_CNT_W  = 4;

    localparam logic [NODE_W-1:0]     FIRST_NODE    = 9'd256;
    localparam logic [BIT_IDX_W-1:0]  TOP_BIT       = 3'd7;
    localparam logic [HDR_IDX_W-1:0]  LAST_HDR_BYTE = 2'd3;
    localparam logic [LEAF_CNT_W-1:0] LAST_LEAF_BIT = 4'd7;

    typedef struct packed {
        logic [SYM_W-1:0] in_byte;
        logic             stream_start;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_symbol;
        logic             error;
    } t_out_item;

    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic [NODE_W-1:0] wr_node;
        logic [NODE_W-1:0] wr_data;
        logic              rd_en;
        logic [NODE_W-1:0] rd_node;
    } t_child_req;

    typedef enum logic [4:0] {
        P_HEADER = 5'b00001,
        P_TREE   = 5'b00010,
        P_LEAF   = 5'b00100,
        P_DECODE = 5'b01000,
        P_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BIT    = 6'b000010,
        S_ATTACH = 6'b000100,
        S_POP    = 6'b001000,
        S_FIN    = 6'b010000,
        S_PREP   = 6'b100000
    } t_seq;

endpackage

/* design/htsd_child_mem.sv */
// Child pointer memories of the internal tree nodes, with registered reads.
module htsd_child_mem
    import htsd_pkg::*;
#(
    parameter int NODE_LIMIT = 511
) (
    input  logic              i_clk,
    input  t_child_req        i_req,
    output logic [NODE_W-1:0] o_left_q,
    output logic [NODE_W-1:0] o_right_q
);

    localparam int DEPTH = NODE_LIMIT - 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [NODE_W-1:0] r_left_mem  [DEPTH];
    logic [NODE_W-1:0] r_right_mem [DEPTH];
    logic [NODE_W-1:0] r_left_q;
    logic [NODE_W-1:0] r_right_q;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_left) begin
            r_left_mem[i_req.wr_node[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.wr_right) begin
            r_right_mem[i_req.wr_node[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_left_q  <= r_left_mem[i_req.rd_node[AW-1:0]];
            r_right_q <= r_right_mem[i_req.rd_node[AW-1:0]];
        end
    end

    assign o_left_q  = r_left_q;
    assign o_right_q = r_right_q;

endmodule

/* design/huffman_tree_stream_decoder.sv */
// Top level of the Huffman decoder that reads its tree from the stream.
//
// Compressed bytes arrive on the input channel (i_in_valid, o_in_stall,
// i_in_data); stream_start on a byte restarts the decoder with that byte as
// the first of the four little-endian count bytes. Decoded symbols leave on
// the output channel (o_out_valid, i_out_stall, o_out_data), the last one
// marked, or a single error transfer when the tree is only a leaf.
// Header bytes and bytes after the end of the stream are taken in the idle
// state. Any other byte is accepted and then worked one bit at a time; each
// completed subtree is attached to its parent node, each node that this
// closes is popped from the build stack, and the root is fetched when
// decoding begins. Bits after the end of the stream are skipped. The build
// stack and child memories have registered reads. Each decoded symbol is
// held in an output register; while that register is full and the receiver
// stalls, the tree walk pauses on the next leaf. Results pass through that
// register before they reach the output. o_in_stall stays high while a byte
// is being worked on. Reset clears the control state and the output valid
// flag; the tree memories keep their contents and need no clearing pass.
module huffman_tree_stream_decoder
    import htsd_pkg::*;
#(
    parameter int NODE_LIMIT = 511
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [NODE_W-1:0] LIMIT_NODE = NODE_W'(NODE_LIMIT);

    t_seq                  r_seq, n_seq;
    t_phase                r_phase, n_phase;
    logic [SYM_W-1:0]      r_byte, n_byte;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [DEPTH_W-1:0]    r_stack_depth, n_stack_depth;
    logic [NODE_W-1:0]     r_next_node, n_next_node;
    logic [NODE_W-1:0]     r_root_node, n_root_node;
    logic [HDR_IDX_W-1:0]  r_header_index, n_header_index;
    logic [COUNT_W-1:0]    r_symbols_left, n_symbols_left;
    logic [NODE_W-1:0]     r_walk_node, n_walk_node;
    logic [SYM_W-1:0]      r_leaf_shift, n_leaf_shift;
    logic [LEAF_CNT_W-1:0] r_leaf_bits, n_leaf_bits;
    logic [NODE_W-1:0]     r_top_node, n_top_node;
    logic                  r_top_flag, n_top_flag;
    logic [NODE_W-1:0]     r_attach_val, n_attach_val;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic [STACK_W-1:0]    r_stack_mem [STACK_DEPTH];
    logic [STACK_W-1:0]    r_stack_q;

    logic                  stk_we;
    logic [STACK_AW-1:0]   stk_waddr;
    logic [STACK_W-1:0]    stk_wdata;
    logic                  stk_re;
    logic [STACK_AW-1:0]   stk_raddr;

    t_child_req            child_req;
    logic [NODE_W-1:0]     left_q;
    logic [NODE_W-1:0]     right_q;

    logic                  in_acc;
    logic                  out_free;
    logic                  cur_bit;
    logic [NODE_W-1:0]     child;
    logic                  adv;
    logic                  emit;
    t_out_item             emit_data;
    t_phase                eff_phase;
    logic [COUNT_W-1:0]    base_count;
    logic [HDR_IDX_W-1:0]  base_index;
    logic [SYM_W-1:0]      shifted_leaf;

    htsd_child_mem #(
        .NODE_LIMIT(NODE_LIMIT)
    ) u_child_mem (
        .i_clk     (i_clk),
        .i_req     (child_req),
        .o_left_q  (left_q),
        .o_right_q (right_q)
    );

    assign in_acc      = i_in_valid && (r_seq == S_IDLE);
    assign o_in_stall  = (r_seq != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign cur_bit     = r_byte[r_bit_idx];
    assign child       = cur_bit ? right_q : left_q;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_seq          = r_seq;
        n_phase        = r_phase;
        n_byte         = r_byte;
        n_bit_idx      = r_bit_idx;
        n_stack_depth  = r_stack_depth;
        n_next_node    = r_next_node;
        n_root_node    = r_root_node;
        n_header_index = r_header_index;
        n_symbols_left = r_symbols_left;
        n_walk_node    = r_walk_node;
        n_leaf_shift   = r_leaf_shift;
        n_leaf_bits    = r_leaf_bits;
        n_top_node     = r_top_node;
        n_top_flag     = r_top_flag;
        n_attach_val   = r_attach_val;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = '0;
        stk_re         = 1'b0;
        stk_raddr      = '0;
        child_req      = '0;
        adv            = 1'b0;
        emit           = 1'b0;
        emit_data      = '0;
        eff_phase      = r_phase;
        base_count     = r_symbols_left;
        base_index     = r_header_index;
        shifted_leaf   = {r_leaf_shift[SYM_W-2:0], cur_bit};

        unique case (r_seq)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.stream_start) begin
                        eff_phase      = P_HEADER;
                        base_count     = '0;
                        base_index     = '0;
                        n_phase        = P_HEADER;
                        n_stack_depth  = '0;
                        n_next_node    = FIRST_NODE;
                        n_root_node    = '0;
                        n_walk_node    = '0;
                        n_leaf_shift   = '0;
                        n_leaf_bits    = '0;
                    end
                    if (eff_phase == P_HEADER) begin
                        n_symbols_left = base_count
                            | ({24'd0, i_in_data.in_byte} << {base_index, 3'b000});
                        if (base_index == LAST_HDR_BYTE) begin
                            n_header_index = '0;
                            n_phase        = P_TREE;
                        end else begin
                            n_header_index = base_index + 1'b1;
                        end
                    end else if (eff_phase != P_DONE) begin
                        n_byte    = i_in_data.in_byte;
                        n_bit_idx = TOP_BIT;
                        n_seq     = S_BIT;
                    end
                end
            end
            S_BIT: begin
                if (r_phase == P_TREE) begin
                    if (cur_bit) begin
                        if ((r_next_node < LIMIT_NODE) && !r_stack_depth[DEPTH_W-1]) begin
                            if (r_stack_depth != '0) begin
                                stk_we    = 1'b1;
                                stk_waddr = STACK_AW'(r_stack_depth - 1'b1);
                                stk_wdata = {r_top_flag, r_top_node};
                            end
                            n_top_node    = r_next_node;
                            n_top_flag    = 1'b0;
                            n_stack_depth = r_stack_depth + 1'b1;
                            n_next_node   = r_next_node + 1'b1;
                            adv           = 1'b1;
                        end else begin
                            n_attach_val = '0;
                            n_seq        = S_ATTACH;
                        end
                    end else begin
                        n_phase      = P_LEAF;
                        n_leaf_shift = '0;
                        n_leaf_bits  = '0;
                        adv          = 1'b1;
                    end
                end else if (r_phase == P_LEAF) begin
                    n_leaf_shift = shifted_leaf;
                    if (r_leaf_bits == LAST_LEAF_BIT) begin
                        n_leaf_bits  = '0;
                        n_phase      = P_TREE;
                        n_attach_val = {1'b0, shifted_leaf};
                        n_seq        = S_ATTACH;
                    end else begin
                        n_leaf_bits = r_leaf_bits + 1'b1;
                        adv         = 1'b1;
                    end
                end else if (r_phase == P_DECODE) begin
                    if (!child[NODE_W-1]) begin
                        if (out_free) begin
                            emit                  = 1'b1;
                            emit_data.symbol      = child[SYM_W-1:0];
                            emit_data.last_symbol = (r_symbols_left == 32'd1);
                            emit_data.error       = 1'b0;
                            n_symbols_left        = r_symbols_left - 1'b1;
                            n_walk_node           = r_root_node;
                            child_req.rd_en       = 1'b1;
                            child_req.rd_node     = r_root_node;
                            if (r_symbols_left == 32'd1) begin
                                n_phase = P_DONE;
                                n_seq   = S_IDLE;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                    end else begin
                        n_walk_node       = child;
                        child_req.rd_en   = 1'b1;
                        child_req.rd_node = child;
                        adv               = 1'b1;
                    end
                end else begin
                    n_seq = S_IDLE;
                end
            end
            S_ATTACH: begin
                if (r_stack_depth == '0) begin
                    n_root_node = r_attach_val;
                    n_seq       = S_FIN;
                end else if (!r_top_flag) begin
                    child_req.wr_left = 1'b1;
                    child_req.wr_node = r_top_node;
                    child_req.wr_data = r_attach_val;
                    n_top_flag        = 1'b1;
                    adv               = 1'b1;
                end else begin
                    child_req.wr_right = 1'b1;
                    child_req.wr_node  = r_top_node;
                    child_req.wr_data  = r_attach_val;
                    n_attach_val       = r_top_node;
                    n_stack_depth      = r_stack_depth - 1'b1;
                    if (r_stack_depth != 9'd1) begin
                        stk_re    = 1'b1;
                        stk_raddr = STACK_AW'(r_stack_depth - 9'd2);
                        n_seq     = S_POP;
                    end
                end
            end
            S_POP: begin
                n_top_node = r_stack_q[NODE_W-1:0];
                n_top_flag = r_stack_q[STACK_W-1];
                n_seq      = S_ATTACH;
            end
            S_FIN: begin
                n_walk_node = r_root_node;
                if (r_symbols_left == '0) begin
                    n_phase = P_DONE;
                    n_seq   = S_IDLE;
                end else if (!r_root_node[NODE_W-1]) begin
                    if (out_free) begin
                        emit                  = 1'b1;
                        emit_data.symbol      = '0;
                        emit_data.last_symbol = 1'b1;
                        emit_data.error       = 1'b1;
                        n_phase               = P_DONE;
                        n_seq                 = S_IDLE;
                    end
                end else begin
                    n_phase = P_DECODE;
                    n_seq   = S_PREP;
                end
            end
            S_PREP: begin
                child_req.rd_en   = 1'b1;
                child_req.rd_node = r_root_node;
                adv               = 1'b1;
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase

        if (adv) begin
            if (r_bit_idx == '0) begin
                n_seq = S_IDLE;
            end else begin
                n_bit_idx = r_bit_idx - 1'b1;
                n_seq     = S_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq          <= S_IDLE;
            r_phase        <= P_HEADER;
            r_bit_idx      <= '0;
            r_stack_depth  <= '0;
            r_next_node    <= FIRST_NODE;
            r_root_node    <= '0;
            r_header_index <= '0;
            r_symbols_left <= '0;
            r_walk_node    <= '0;
            r_leaf_shift   <= '0;
            r_leaf_bits    <= '0;
            r_top_flag     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_seq          <= n_seq;
            r_phase        <= n_phase;
            r_bit_idx      <= n_bit_idx;
            r_stack_depth  <= n_stack_depth;
            r_next_node    <= n_next_node;
            r_root_node    <= n_root_node;
            r_header_index <= n_header_index;
            r_symbols_left <= n_symbols_left;
            r_walk_node    <= n_walk_node;
            r_leaf_shift   <= n_leaf_shift;
            r_leaf_bits    <= n_leaf_bits;
            r_top_flag     <= n_top_flag;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_top_node   <= n_top_node;
        r_attach_val <= n_attach_val;
        if (emit) begin
            r_out_data <= emit_data;
        end
        if (stk_we) begin
            r_stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_q <= r_stack_mem[stk_raddr];
        end
    end

endmodule
